// ----- design/ibl_pkg.sv -----
`timescale 1ns / 1ps

package ibl_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned MAX_INDENT_LEVELS_DEF = 32;
    localparam int unsigned NODE_INDEX_BITS_DEF   = 16;

    // Fixed width of the indent field.
    localparam int unsigned INDENT_W = 5;

    // Depth of the command queue between the front and the back.
    localparam int unsigned CMD_DEPTH = 2;

    // Codes of the action field.
    localparam logic ACTION_NODE = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    // Codes of the kind field.
    localparam logic KIND_CLOSE = 1'b0;
    localparam logic KIND_LINK  = 1'b1;

    // Command class decided by the front.
    typedef enum logic [1:0] {
        OP_NODE,
        OP_END,
        OP_OVF
    } t_op;

    // Control part of a command; the node counter travels beside it.
    typedef struct packed {
        t_op                 op;
        logic [INDENT_W-1:0] indent;
        logic                opens;
    } t_ctl;

    localparam int unsigned CTL_W = $bits(t_ctl);

endpackage

// ----- design/ibl_front.sv -----
`timescale 1ns / 1ps

module ibl_front #(
    parameter int unsigned MAX_LVL = 32,
    parameter int unsigned NB      = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_fifo_full,
    input  logic                         i_action,
    input  logic [ibl_pkg::INDENT_W-1:0] i_indent,
    input  logic                         i_opens_block,
    output logic                         o_wr,
    output ibl_pkg::t_ctl                o_ctl,
    output logic [NB:0]                  o_count
);
    import ibl_pkg::*;

    // Highest indent that the level table can hold.
    localparam int unsigned MAX_IND =
        (MAX_LVL - 1 > (1 << INDENT_W) - 1) ? (1 << INDENT_W) - 1 : MAX_LVL - 1;

    logic [NB:0] r_count;
    logic [NB:0] n_count;
    logic        accept;

    assign accept  = i_push & ~i_fifo_full;
    assign o_wr    = accept;
    assign o_count = r_count;

    always_comb begin
        o_ctl.opens  = i_opens_block;
        o_ctl.indent = (i_indent > INDENT_W'(MAX_IND)) ? INDENT_W'(MAX_IND) : i_indent;
        if (i_action == ACTION_END) begin
            o_ctl.op = OP_END;
        end else if (r_count[NB]) begin
            o_ctl.op = OP_OVF;
        end else begin
            o_ctl.op = OP_NODE;
        end

        n_count = r_count;
        if (accept) begin
            case (o_ctl.op)
                OP_END:  n_count = '0;
                OP_NODE: n_count = r_count + (NB+1)'(1);
                default: n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ----- design/ibl_cmd_fifo.sv -----
`timescale 1ns / 1ps

module ibl_cmd_fifo #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    input  logic         i_rd,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic [CW-1:0] n_cnt;
    logic          do_wr;
    logic          do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_wr   = i_wr & ~o_full;
    assign do_rd   = i_rd & ~o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        case ({do_wr, do_rd})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // A write is never offered while the queue is full.
    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("command written into a full queue");

endmodule

// ----- design/ibl_back.sv -----
`timescale 1ns / 1ps

module ibl_back #(
    parameter int unsigned MAX_LVL = 32,
    parameter int unsigned NB      = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_vld,
    input  ibl_pkg::t_ctl       i_ctl,
    input  logic [NB:0]         i_count,
    output logic                o_deq,
    input  logic                i_pop,
    output logic                o_empty,
    output logic                o_kind,
    output logic [NB-1:0]       o_node,
    output logic [NB:0]         o_after_block,
    output logic                o_has_prev,
    output logic [NB-1:0]       o_prev,
    output logic                o_has_parent,
    output logic [NB-1:0]       o_parent,
    output logic                o_first_of_parent,
    output logic                o_overflow,
    output logic                o_last
);
    import ibl_pkg::*;

    localparam int unsigned LW = (MAX_LVL > 1) ? $clog2(MAX_LVL) : 1;
    localparam int unsigned CW = $clog2(MAX_LVL + 1);

    // Open-block stack and per-level last-node table.
    logic [NB-1:0]       r_stk_idx [MAX_LVL];
    logic [INDENT_W-1:0] r_stk_ind [MAX_LVL];
    logic                r_stk_hc  [MAX_LVL];
    logic [CW-1:0]       r_depth;
    logic [CW-1:0]       n_depth;
    logic                r_lvl_vld [MAX_LVL];
    logic [NB-1:0]       r_lvl_idx [MAX_LVL];

    // Result register.
    logic                r_out_vld;
    logic                r_kind;
    logic [NB-1:0]       r_node;
    logic [NB:0]         r_after;
    logic                r_has_prev;
    logic [NB-1:0]       r_prev;
    logic                r_has_parent;
    logic [NB-1:0]       r_parent;
    logic                r_first;
    logic                r_ovf;
    logic                r_last;

    logic                n_kind;
    logic [NB-1:0]       n_node;
    logic [NB:0]         n_after;
    logic                n_has_prev;
    logic [NB-1:0]       n_prev;
    logic                n_has_parent;
    logic [NB-1:0]       n_parent;
    logic                n_first;
    logic                n_ovf;
    logic                n_last;

    logic                slot_free;
    logic                emit;
    logic                has_top;
    logic [LW-1:0]       top_ptr;
    logic [LW-1:0]       below_ptr;
    logic [INDENT_W-1:0] top_ind;
    logic [LW-1:0]       lvl;
    logic [NB-1:0]       cur_idx;
    logic                parent_hit;
    logic                push_ok;
    logic                link_upd;
    logic                hc_set;
    logic                clr_all;

    assign slot_free = ~r_out_vld | i_pop;
    assign has_top   = (r_depth != '0);
    assign top_ptr   = LW'(r_depth - CW'(1));
    assign below_ptr = LW'(r_depth - CW'(2));
    assign top_ind   = r_stk_ind[top_ptr];
    assign lvl       = LW'(i_ctl.indent);
    assign cur_idx   = i_count[NB-1:0];
    assign parent_hit = has_top &&
        ({1'b0, i_ctl.indent} == ({1'b0, top_ind} + (INDENT_W+1)'(1)));
    assign push_ok   = i_ctl.opens && (r_depth < CW'(MAX_LVL));

    always_comb begin
        emit         = 1'b0;
        o_deq        = 1'b0;
        n_depth      = r_depth;
        link_upd     = 1'b0;
        hc_set       = 1'b0;
        clr_all      = 1'b0;
        n_kind       = KIND_CLOSE;
        n_node       = '0;
        n_after      = '0;
        n_has_prev   = 1'b0;
        n_prev       = '0;
        n_has_parent = 1'b0;
        n_parent     = '0;
        n_first      = 1'b0;
        n_ovf        = 1'b0;
        n_last       = 1'b0;

        if (i_cmd_vld && slot_free) begin
            case (i_ctl.op)
                OP_NODE: begin
                    if (has_top && (top_ind >= i_ctl.indent)) begin
                        // Close one block per cycle while the result slot is free, until the top is shallower.
                        emit    = 1'b1;
                        n_node  = r_stk_idx[top_ptr];
                        n_after = i_count;
                        n_depth = r_depth - CW'(1);
                    end else begin
                        emit         = 1'b1;
                        o_deq        = 1'b1;
                        link_upd     = 1'b1;
                        hc_set       = parent_hit;
                        n_kind       = KIND_LINK;
                        n_node       = cur_idx;
                        n_has_prev   = r_lvl_vld[lvl];
                        n_prev       = r_lvl_vld[lvl] ? r_lvl_idx[lvl] : '0;
                        n_has_parent = parent_hit;
                        n_parent     = parent_hit ? r_stk_idx[top_ptr] : '0;
                        n_first      = parent_hit & ~r_stk_hc[top_ptr];
                        n_last       = 1'b1;
                        n_depth      = push_ok ? r_depth + CW'(1) : r_depth;
                    end
                end
                OP_END: begin
                    if (has_top) begin
                        emit    = 1'b1;
                        n_node  = r_stk_idx[top_ptr];
                        n_after = i_count;
                        n_last  = (r_depth == CW'(1));
                        n_depth = r_depth - CW'(1);
                        o_deq   = (r_depth == CW'(1));
                        clr_all = (r_depth == CW'(1));
                    end else begin
                        o_deq   = 1'b1;
                        clr_all = 1'b1;
                    end
                end
                OP_OVF: begin
                    emit   = 1'b1;
                    o_deq  = 1'b1;
                    n_kind = KIND_LINK;
                    n_ovf  = 1'b1;
                    n_last = 1'b1;
                end
                default: begin
                    o_deq = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < MAX_LVL; i++) begin
                r_lvl_vld[i] <= 1'b0;
            end
        end else begin
            r_depth   <= n_depth;
            r_out_vld <= emit | (r_out_vld & ~i_pop);
            for (int i = 0; i < MAX_LVL; i++) begin
                if (clr_all) begin
                    r_lvl_vld[i] <= 1'b0;
                end else if (link_upd) begin
                    if (LW'(i) > lvl) begin
                        r_lvl_vld[i] <= 1'b0;
                    end else if (LW'(i) == lvl) begin
                        r_lvl_vld[i] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind       <= n_kind;
            r_node       <= n_node;
            r_after      <= n_after;
            r_has_prev   <= n_has_prev;
            r_prev       <= n_prev;
            r_has_parent <= n_has_parent;
            r_parent     <= n_parent;
            r_first      <= n_first;
            r_ovf        <= n_ovf;
            r_last       <= n_last;
        end
        if (link_upd) begin
            r_lvl_idx[lvl] <= cur_idx;
            if (push_ok) begin
                r_stk_idx[LW'(r_depth)] <= cur_idx;
                r_stk_ind[LW'(r_depth)] <= i_ctl.indent;
                r_stk_hc[LW'(r_depth)]  <= 1'b0;
            end
        end
        if (hc_set) begin
            r_stk_hc[top_ptr] <= 1'b1;
        end
    end

    assign o_empty           = ~r_out_vld;
    assign o_kind            = r_kind;
    assign o_node            = r_node;
    assign o_after_block     = r_after;
    assign o_has_prev        = r_has_prev;
    assign o_prev            = r_prev;
    assign o_has_parent      = r_has_parent;
    assign o_parent          = r_parent;
    assign o_first_of_parent = r_first;
    assign o_overflow        = r_ovf;
    assign o_last            = r_last;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CW'(MAX_LVL))
        else $error("open-block stack deeper than its storage");

    a_stack_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth >= CW'(2)) |-> (r_stk_ind[top_ptr] > r_stk_ind[below_ptr]))
        else $error("open-block indents do not increase toward the top");

    a_end_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_deq && i_ctl.op == OP_END) |=> (r_depth == '0))
        else $error("end of list left blocks open");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_pop) |-> !emit)
        else $error("result overwritten before it was taken");

endmodule

// ----- design/indentation_block_linker.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------------------------
// node in  | input     | i_push / o_full         | i_action, i_indent, i_opens_block
// result   | output    | o_empty / i_pop         | o_kind, o_node, o_after_block, o_has_prev,
//          |           |                         | o_prev, o_has_parent, o_parent,
//          |           |                         | o_first_of_parent, o_overflow, o_last
//
// The front takes one word per cycle into a two-entry command queue while it is not full.
// For a node the back emits a close record for each open block whose indent is not
// shallower, then the link record; an end word emits a close record for each open block,
// or none when no block is open. The open-block stack walk sets how long a word takes.
// Reset is synchronous and active low; it empties the queue and the result register,
// clears the node counter, the stack depth and all level valid bits at once.
// When the result register is full and not popped the back holds, and the front keeps
// taking words until the queue fills.

module indentation_block_linker #(
    parameter int unsigned MAX_INDENT_LEVELS = ibl_pkg::MAX_INDENT_LEVELS_DEF,
    parameter int unsigned NODE_INDEX_BITS   = ibl_pkg::NODE_INDEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_action,
    input  logic [ibl_pkg::INDENT_W-1:0] i_indent,
    input  logic                         i_opens_block,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic                         o_kind,
    output logic [NODE_INDEX_BITS-1:0]   o_node,
    output logic [NODE_INDEX_BITS:0]     o_after_block,
    output logic                         o_has_prev,
    output logic [NODE_INDEX_BITS-1:0]   o_prev,
    output logic                         o_has_parent,
    output logic [NODE_INDEX_BITS-1:0]   o_parent,
    output logic                         o_first_of_parent,
    output logic                         o_overflow,
    output logic                         o_last
);
    import ibl_pkg::*;

    localparam int unsigned NB    = NODE_INDEX_BITS;
    localparam int unsigned CMD_W = CTL_W + NB + 1;

    // The front classifies each word (node, end of list, or counter overflow),
    // clamps the indent to the table range and numbers it.
    logic         front_wr;
    t_ctl         front_ctl;
    logic [NB:0]  front_count;

    // Command queue between the front and the back.
    logic [CMD_W-1:0] q_wdata;
    logic [CMD_W-1:0] q_rdata;
    logic             q_empty;
    logic             q_full;
    logic             back_deq;
    t_ctl             back_ctl;
    logic [NB:0]      back_count;

    assign o_full  = q_full;
    assign q_wdata = {front_ctl, front_count};
    assign back_ctl   = t_ctl'(q_rdata[CMD_W-1 -: CTL_W]);
    assign back_count = q_rdata[NB:0];

    ibl_front #(
        .MAX_LVL (MAX_INDENT_LEVELS),
        .NB      (NB)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_fifo_full   (q_full),
        .i_action      (i_action),
        .i_indent      (i_indent),
        .i_opens_block (i_opens_block),
        .o_wr          (front_wr),
        .o_ctl         (front_ctl),
        .o_count       (front_count)
    );

    ibl_cmd_fifo #(
        .W     (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_data  (q_wdata),
        .i_rd    (back_deq),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back owns the open-block stack, the per-level table and the result register.
    ibl_back #(
        .MAX_LVL (MAX_INDENT_LEVELS),
        .NB      (NB)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_vld         (~q_empty),
        .i_ctl             (back_ctl),
        .i_count           (back_count),
        .o_deq             (back_deq),
        .i_pop             (i_pop),
        .o_empty           (o_empty),
        .o_kind            (o_kind),
        .o_node            (o_node),
        .o_after_block     (o_after_block),
        .o_has_prev        (o_has_prev),
        .o_prev            (o_prev),
        .o_has_parent      (o_has_parent),
        .o_parent          (o_parent),
        .o_first_of_parent (o_first_of_parent),
        .o_overflow        (o_overflow),
        .o_last            (o_last)
    );

endmodule

// ----- tb/sv/indentation_block_linker_tb.sv -----
`timescale 1ns / 1ps

// Testbench for the indentation block linker.
//
// A queue of node words is filled at time zero: a short hand-picked list first, then random
// node lists that mostly follow the offside rule, then a short list after an end word. A
// clocked driver offers those words in bursts. A clocked monitor pops the results on a stall
// pattern of its own and compares every field with the oldest record that the predictor in
// this file worked out when the word was accepted.

module indentation_block_linker_tb;

    import ibl_pkg::*;

    localparam int unsigned LEVELS      = MAX_INDENT_LEVELS_DEF;
    localparam int unsigned IDX_W       = NODE_INDEX_BITS_DEF;
    localparam int unsigned CAPACITY    = 1 << IDX_W;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    // The receiver holds off once, early in the random lists, long enough to back up the
    // command queue and the result register so that o_full stalls the sender.
    localparam int unsigned HOLD_START  = 150;
    localparam int unsigned HOLD_CYCLES = 240;
    // After the last record, one word can still walk a full stack before it goes quiet.
    localparam int unsigned DRAIN       = 48;

    typedef struct packed {
        logic                action;
        logic [INDENT_W-1:0] indent;
        logic                opens;
    } t_node_word;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] node;
        logic [IDX_W:0]   after_idx;
        logic             has_prev;
        logic [IDX_W-1:0] prev;
        logic             has_parent;
        logic [IDX_W-1:0] parent;
        logic             first_of_parent;
        logic             overflow;
        logic             last;
    } t_link_rec;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_push        = 1'b0;
    logic                  i_action      = 1'b0;
    logic [INDENT_W-1:0]   i_indent      = '0;
    logic                  i_opens_block = 1'b0;
    logic                  i_pop         = 1'b0;
    logic                  o_full;
    logic                  o_empty;
    logic                  o_kind;
    logic [IDX_W-1:0]      o_node;
    logic [IDX_W:0]        o_after_block;
    logic                  o_has_prev;
    logic [IDX_W-1:0]      o_prev;
    logic                  o_has_parent;
    logic [IDX_W-1:0]      o_parent;
    logic                  o_first_of_parent;
    logic                  o_overflow;
    logic                  o_last;

    indentation_block_linker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_action         (i_action),
        .i_indent         (i_indent),
        .i_opens_block    (i_opens_block),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_kind           (o_kind),
        .o_node           (o_node),
        .o_after_block    (o_after_block),
        .o_has_prev       (o_has_prev),
        .o_prev           (o_prev),
        .o_has_parent     (o_has_parent),
        .o_parent         (o_parent),
        .o_first_of_parent(o_first_of_parent),
        .o_overflow       (o_overflow),
        .o_last           (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Words waiting to be offered, and records waiting to come out, oldest first.
    t_node_word node_words[$];
    t_link_rec  awaited_records[$];

    // The predictor's own copy of the block state.
    logic [IDX_W:0]        node_ctr = '0;
    logic [IDX_W-1:0]      blk_idx       [LEVELS];
    logic [INDENT_W-1:0]   blk_ind       [LEVELS];
    logic                  blk_has_child [LEVELS];
    int                    blk_depth = 0;
    logic                  lvl_valid     [LEVELS];
    logic [IDX_W-1:0]      lvl_idx       [LEVELS];

    // Shape of the open blocks as the stimulus generator sees it, used to build lists that
    // follow the offside rule.
    int gen_open[$];

    int cycles       = 0;
    int mismatches   = 0;
    int records_seen = 0;
    int node_count   = 0;
    int end_count    = 0;
    int close_count  = 0;
    int link_count   = 0;
    int ovf_count    = 0;
    int most_records = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at cycle %0d, record %0d: %s", cycles, records_seen, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Pops the top open block and queues its close record.
    task automatic close_top_block(input logic is_last);
        t_link_rec r;
        r           = '0;
        r.kind      = KIND_CLOSE;
        r.node      = blk_idx[blk_depth-1];
        r.after_idx = node_ctr;
        r.last      = is_last;
        awaited_records.insert(awaited_records.size(), r);
        blk_depth--;
    endtask

    // Works out every record that one accepted word causes and updates the predicted state.
    task automatic derive_records(input t_node_word w);
        t_link_rec r;
        int        ind;
        int        produced;
        produced = awaited_records.size();
        if (w.action == ACTION_END) begin
            // Closing everything; the final close carries the last mark.
            while (blk_depth > 0) begin
                close_top_block(blk_depth == 1);
            end
            node_ctr = '0;
            for (int lv = 0; lv < LEVELS; lv++) begin
                lvl_valid[lv] = 1'b0;
            end
        end else if (node_ctr == CAPACITY) begin
            // The counter is full: the node is dropped and only the overflow flag is reported.
            r          = '0;
            r.kind     = KIND_LINK;
            r.overflow = 1'b1;
            r.last     = 1'b1;
            awaited_records.insert(awaited_records.size(), r);
        end else begin
            ind = w.indent;
            if (ind >= LEVELS) begin
                ind = LEVELS - 1;
            end
            while (blk_depth > 0 && blk_ind[blk_depth-1] >= ind) begin
                close_top_block(1'b0);
            end
            r      = '0;
            r.kind = KIND_LINK;
            r.node = node_ctr[IDX_W-1:0];
            // Anything deeper than this node can no longer be its sibling.
            for (int lv = ind + 1; lv < LEVELS; lv++) begin
                lvl_valid[lv] = 1'b0;
            end
            if (lvl_valid[ind]) begin
                r.has_prev = 1'b1;
                r.prev     = lvl_idx[ind];
            end
            // A parent exists only for a node exactly one level inside the top open block.
            if (blk_depth > 0 && ind == blk_ind[blk_depth-1] + 1) begin
                r.has_parent                = 1'b1;
                r.parent                    = blk_idx[blk_depth-1];
                r.first_of_parent           = !blk_has_child[blk_depth-1];
                blk_has_child[blk_depth-1]  = 1'b1;
            end
            r.last = 1'b1;
            awaited_records.insert(awaited_records.size(), r);
            lvl_valid[ind] = 1'b1;
            lvl_idx[ind]   = node_ctr[IDX_W-1:0];
            if (w.opens && blk_depth < LEVELS) begin
                blk_idx[blk_depth]       = node_ctr[IDX_W-1:0];
                blk_ind[blk_depth]       = INDENT_W'(ind);
                blk_has_child[blk_depth] = 1'b0;
                blk_depth++;
            end
            node_ctr++;
        end
        produced = awaited_records.size() - produced;
        if (produced > most_records) begin
            most_records = produced;
        end
    endtask

    // Queues one word and mirrors its effect on the block nesting.
    task automatic add_word(input logic action, input int indent, input logic opens);
        t_node_word w;
        w.action = action;
        w.indent = INDENT_W'(indent);
        w.opens  = opens;
        node_words.insert(node_words.size(), w);
        if (action == ACTION_END) begin
            gen_open.delete();
            end_count++;
        end else begin
            while (gen_open.size() > 0 && gen_open[$] >= indent) begin
                gen_open.delete(gen_open.size() - 1);
            end
            if (opens) begin
                gen_open.insert(gen_open.size(), indent);
            end
            node_count++;
        end
    endtask

    // Driver: bursts of random length separated by random gaps; a word refused by o_full
    // stays on the ports until it is taken.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : driver
        logic offer;
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                derive_records(node_words.pop_front());
            end
            offer = 1'b0;
            if (i_push && o_full) begin
                offer = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (node_words.size() > 0) begin
                offer = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            i_push <= offer;
            if (offer) begin
                i_action      <= node_words[0].action;
                i_indent      <= node_words[0].indent;
                i_opens_block <= node_words[0].opens;
            end
        end
    end

    // Monitor: checks each popped record, then picks the next pop from a rotating pattern
    // that is redrawn at random whenever pattern_age wraps, with one long hold-off.
    logic [7:0] pop_pattern = 8'hFF;
    int         pattern_age = 0;
    int         hold_left   = 0;
    bit         hold_done   = 1'b0;

    always @(posedge i_clk) begin : monitor
        t_link_rec want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (awaited_records.size() == 0) begin
                    report_mismatch($sformatf("record with nothing expected, node %0h", o_node));
                end else begin
                    want = awaited_records.pop_front();
                    check_field("kind", 32'(o_kind), 32'(want.kind));
                    check_field("node", 32'(o_node), 32'(want.node));
                    check_field("after", 32'(o_after_block), 32'(want.after_idx));
                    check_field("has_prev", 32'(o_has_prev), 32'(want.has_prev));
                    check_field("prev", 32'(o_prev), 32'(want.prev));
                    check_field("has_parent", 32'(o_has_parent), 32'(want.has_parent));
                    check_field("parent", 32'(o_parent), 32'(want.parent));
                    check_field("first_of_parent", 32'(o_first_of_parent),
                                32'(want.first_of_parent));
                    check_field("overflow", 32'(o_overflow), 32'(want.overflow));
                    check_field("last", 32'(o_last), 32'(want.last));
                    if (want.overflow) begin
                        ovf_count++;
                    end else if (want.kind == KIND_CLOSE) begin
                        close_count++;
                    end else begin
                        link_count++;
                    end
                end
                records_seen++;
            end
            if (!hold_done && cycles >= HOLD_START) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop       <= pop_pattern[0];
                pop_pattern  = {pop_pattern[0], pop_pattern[7:1]};
                pattern_age++;
                if (pattern_age == 64) begin
                    pattern_age = 0;
                    // A quarter of the time the receiver never stalls.
                    pop_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF :
                                  8'($urandom_range(1, 255));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("indentation_block_linker_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int budget;
        int chains;
        int list_len;
        int pick;
        int k;
        int ind;

        for (int lv = 0; lv < LEVELS; lv++) begin
            lvl_valid[lv] = 1'b0;
        end

        // Hand-picked list. An end word with nothing open gives no record at all.
        add_word(ACTION_END, 0, 1'b0);
        add_word(ACTION_NODE, 0, 1'b1);   // node 0 opens a block
        add_word(ACTION_NODE, 1, 1'b0);   // first child of node 0
        add_word(ACTION_NODE, 1, 1'b1);   // second child, sibling of node 1
        add_word(ACTION_NODE, 2, 1'b0);   // first child of node 2
        add_word(ACTION_NODE, 4, 1'b1);   // jumps two levels: no parent, no sibling
        add_word(ACTION_NODE, 3, 1'b0);   // closes node 4, still no parent
        add_word(ACTION_NODE, 2, 1'b0);   // sibling of node 3, child of node 2
        add_word(ACTION_NODE, 0, 1'b0);   // closes nodes 2 and 0, sibling of node 0
        add_word(ACTION_NODE, 31, 1'b1);  // deepest level opens a block
        add_word(ACTION_NODE, 31, 1'b1);  // closes its own level's block, sibling of it
        add_word(ACTION_END, 31, 1'b1);   // closes the last block
        add_word(ACTION_END, 17, 1'b0);   // nothing left to close
        add_word(ACTION_NODE, 0, 1'b0);   // counter starts again from zero

        // Random lists: mostly well-formed nesting, some arbitrary indents and early ends,
        // and now and then a full 32-deep chain that one outdent closes in a single word.
        budget   = 385;
        chains   = 0;
        list_len = 1;
        while (budget > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 6 && list_len > 4) begin
                add_word(ACTION_END, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
                list_len = 0;
                budget--;
            end else if (pick < 9 && chains < 3 && budget > 40) begin
                for (int lv = 0; lv < LEVELS; lv++) begin
                    add_word(ACTION_NODE, lv, 1'b1);
                end
                add_word(ACTION_NODE, 0, 1'($urandom_range(0, 1)));
                chains++;
                list_len += LEVELS + 1;
                budget   -= LEVELS + 1;
            end else if (pick < 22) begin
                add_word(ACTION_NODE, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
                list_len++;
                budget--;
            end else begin
                if (gen_open.size() > 0 && $urandom_range(0, 99) < 55) begin
                    ind = gen_open[$] + 1;
                end else begin
                    k   = $urandom_range(0, gen_open.size());
                    ind = (k == gen_open.size()) ? 0 : gen_open[k] + 1;
                end
                if (ind > 31) begin
                    ind = 31;
                end
                add_word(ACTION_NODE, ind, $urandom_range(0, 99) < 45);
                list_len++;
                budget--;
            end
        end

        // Close whatever the random lists left open, then a short list shows that numbering
        // starts over.
        add_word(ACTION_END, 0, 1'b0);
        add_word(ACTION_NODE, 0, 1'b1);
        add_word(ACTION_NODE, 1, 1'b1);
        add_word(ACTION_NODE, 2, 1'b0);
        add_word(ACTION_NODE, 1, 1'b0);
        add_word(ACTION_END, 0, 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample a little after the edge so that the driver and the monitor have settled.
        while (node_words.size() > 0 || i_push || awaited_records.size() > 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (DRAIN) @(posedge i_clk);
        #1;
        if (awaited_records.size() > 0) begin
            report_mismatch($sformatf("%0d records never came out", awaited_records.size()));
        end

        $display("run covered %0d node words and %0d end words, up to %0d records per word",
                 node_count, end_count, most_records);
        $display("checked %0d link, %0d close and %0d overflow records",
                 link_count, close_count, ovf_count);
        if (mismatches == 0) begin
            $display("indentation_block_linker_tb: PASS");
        end else begin
            $display("indentation_block_linker_tb: FAIL");
        end
        $finish;
    end

endmodule
